FILE: design/awbg_pkg.sv
// Shared constants and register indexes for the white balance gain pipeline.
`default_nettype none

package awbg_pkg;

	// Width of the ratio, gain and configuration fields at the ports.
	localparam int FIELD_W = 16;
	localparam int GAIN_W = 16;

	// Relative gains are scaled by this factor; it also serves as the default base.
	localparam int REL_SCALE = 1000;
	localparam int BASE_W = 10;

	// Unity channel gain is one shifted up by UNITY_SHIFT.
	localparam int UNITY_SHIFT = 10;
	localparam int UNITY_GAIN = 1 << UNITY_SHIFT;
	localparam int REL_SHIFT = GAIN_W - UNITY_SHIFT;

	// Channel lanes of the gain divider.
	localparam int LANE_RED = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE = 2;
	localparam int GAIN_LANES = 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GOLDEN_RG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GOLDEN_BG = 1'b1;

endpackage

`default_nettype wire

FILE: design/awbg_div_cell.sv
// One restoring division step for several lanes, registered, with a shared valid and sideband.
`default_nettype none

module awbg_div_cell #(
	parameter int LANES = 2,
	parameter int DW = 16,
	parameter int NW = 26,
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [SW-1:0]               in_side,
	input  logic [LANES-1:0][DW-1:0]    in_rem,
	input  logic [LANES-1:0][DW-1:0]    in_div,
	input  logic [LANES-1:0][NW-1:0]    in_num,
	input  logic [LANES-1:0][NW-1:0]    in_quo,
	output logic                        out_valid,
	output logic [SW-1:0]               out_side,
	output logic [LANES-1:0][DW-1:0]    out_rem,
	output logic [LANES-1:0][DW-1:0]    out_div,
	output logic [LANES-1:0][NW-1:0]    out_num,
	output logic [LANES-1:0][NW-1:0]    out_quo
);

	logic [LANES-1:0][DW:0]   trial;
	logic [LANES-1:0][DW:0]   diff;
	logic [LANES-1:0]         ge;
	logic [LANES-1:0][DW-1:0] rem_d;
	logic [LANES-1:0][NW-1:0] num_d;
	logic [LANES-1:0][NW-1:0] quo_d;

	logic                     valid_q;
	logic [SW-1:0]            side_q;
	logic [LANES-1:0][DW-1:0] rem_q;
	logic [LANES-1:0][DW-1:0] div_q;
	logic [LANES-1:0][NW-1:0] num_q;
	logic [LANES-1:0][NW-1:0] quo_q;

	// Bring down the next numerator bit and subtract the divisor where it fits.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {in_rem[l], in_num[l][NW-1]};
			diff[l]  = trial[l] - {1'b0, in_div[l]};
			ge[l]    = (trial[l] >= {1'b0, in_div[l]});
			rem_d[l] = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
			num_d[l] = {in_num[l][NW-2:0], 1'b0};
			quo_d[l] = {in_quo[l][NW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= in_side;
		rem_q  <= rem_d;
		div_q  <= in_div;
		num_q  <= num_d;
		quo_q  <= quo_d;
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_rem   = rem_q;
	assign out_div   = div_q;
	assign out_num   = num_q;
	assign out_quo   = quo_q;

endmodule

`default_nettype wire

FILE: design/awbg_div_chain.sv
// Row of division cells that produces one quotient bit per cell for every lane.
`default_nettype none

module awbg_div_chain #(
	parameter int LANES = 2,
	parameter int DW = 16,
	parameter int NW = 26,
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [SW-1:0]               in_side,
	input  logic [LANES-1:0][DW-1:0]    in_rem,
	input  logic [LANES-1:0][DW-1:0]    in_div,
	input  logic [LANES-1:0][NW-1:0]    in_num,
	output logic                        out_valid,
	output logic [SW-1:0]               out_side,
	output logic [LANES-1:0][NW-1:0]    out_quo
);

	logic [NW:0]                       valid_w;
	logic [NW:0][SW-1:0]               side_w;
	logic [NW:0][LANES-1:0][DW-1:0]    rem_w;
	logic [NW:0][LANES-1:0][DW-1:0]    div_w;
	logic [NW:0][LANES-1:0][NW-1:0]    num_w;
	logic [NW:0][LANES-1:0][NW-1:0]    quo_w;

	assign valid_w[0] = in_valid;
	assign side_w[0]  = in_side;
	assign rem_w[0]   = in_rem;
	assign div_w[0]   = in_div;
	assign num_w[0]   = in_num;
	assign quo_w[0]   = '0;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		awbg_div_cell #(
			.LANES(LANES),
			.DW   (DW),
			.NW   (NW),
			.SW   (SW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_w[i]),
			.in_side  (side_w[i]),
			.in_rem   (rem_w[i]),
			.in_div   (div_w[i]),
			.in_num   (num_w[i]),
			.in_quo   (quo_w[i]),
			.out_valid(valid_w[i+1]),
			.out_side (side_w[i+1]),
			.out_rem  (rem_w[i+1]),
			.out_div  (div_w[i+1]),
			.out_num  (num_w[i+1]),
			.out_quo  (quo_w[i+1])
		);
	end

	assign out_valid = valid_w[NW];
	assign out_side  = side_w[NW];
	assign out_quo   = quo_w[NW];

endmodule

`default_nettype wire

FILE: design/awb_gain_from_ratios.sv
// Top level: white balance channel gains from measured and golden colour ratios.
//
//  Channel   Signals                                   Handshake
//  -------   ---------------------------------------   ------------------------------
//  request   start, busy, unit_rg, unit_bg             taken when start=1 and busy=0
//  result    done, status, *_gain, *_write, gain_sat.  one cycle strobe on done
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data written when valid and ready
//
// Every request is answered by a pipeline built from two rows of division cells: one cell
// per quotient bit of the relative gains, then sixteen cells for the channel gains, plus
// three register stages for the captured request, the base and the result. A new request
// is taken in every cycle, so busy stays low.
// The asynchronous reset empties the pipeline and clears both golden ratios.
// The receiver of results cannot stall, so nothing in the pipeline ever holds.
`default_nettype none

module awb_gain_from_ratios #(
	parameter int RATIO_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [awbg_pkg::FIELD_W-1:0]           unit_rg,
	input  logic [awbg_pkg::FIELD_W-1:0]           unit_bg,
	output logic                                   done,
	output logic                                   status,
	output logic [awbg_pkg::GAIN_W-1:0]            red_gain,
	output logic [awbg_pkg::GAIN_W-1:0]            green_gain,
	output logic [awbg_pkg::GAIN_W-1:0]            blue_gain,
	output logic                                   red_write,
	output logic                                   green_write,
	output logic                                   blue_write,
	output logic                                   gain_saturated,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [awbg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [awbg_pkg::FIELD_W-1:0]           cfg_data
);

	// Only the low RATIO_WIDTH bits of each ratio take part; the fields are 16 bits wide.
	localparam int EW = (RATIO_WIDTH < awbg_pkg::FIELD_W) ? RATIO_WIDTH : awbg_pkg::FIELD_W;
	// A ratio times 1000 fits in ten more bits, and so does the relative gain.
	localparam int REL_W = EW + awbg_pkg::UNITY_SHIFT;
	localparam int HI_W = REL_W - awbg_pkg::REL_SHIFT;
	localparam int BW = awbg_pkg::BASE_W;
	localparam int GW = awbg_pkg::GAIN_W;
	localparam int NL = awbg_pkg::GAIN_LANES;

	// Configuration registers.
	logic [awbg_pkg::FIELD_W-1:0] golden_rg_q;
	logic [awbg_pkg::FIELD_W-1:0] golden_bg_q;

	// Stage 1: captured request with the golden ratios it is measured against.
	logic          valid_s1;
	logic          zero_s1;
	logic [EW-1:0] urg_s1;
	logic [EW-1:0] ubg_s1;
	logic [EW-1:0] grg_s1;
	logic [EW-1:0] gbg_s1;

	// Relative gain divider.
	logic [1:0][EW-1:0]    rel_div;
	logic [1:0][REL_W-1:0] rel_num;
	logic                  rel_valid;
	logic [0:0]            rel_side;
	logic [1:0][REL_W-1:0] rel_quo;

	// Stage 2: relative gains and the common base.
	logic                  lt_r;
	logic                  lt_b;
	logic [REL_W-1:0]      min_rel;
	logic [BW-1:0]         base_d;
	logic                  valid_s2;
	logic                  status_s2;
	logic [REL_W-1:0]      rel_r_s2;
	logic [REL_W-1:0]      rel_b_s2;
	logic [BW-1:0]         base_s2;

	// Channel gain divider.
	logic [NL-1:0][REL_W-1:0] chan_rel;
	logic [NL-1:0][HI_W-1:0]  chan_hi;
	logic [NL-1:0]            chan_sat;
	logic [NL-1:0][BW-1:0]    gain_rem;
	logic [NL-1:0][BW-1:0]    gain_div;
	logic [NL-1:0][GW-1:0]    gain_num;
	logic                     gain_valid;
	logic [NL:0]              gain_side;
	logic [NL-1:0][GW-1:0]    gain_quo;

	// Stage 3: result registers.
	logic [NL-1:0][GW-1:0]    gain_d;
	logic [NL-1:0]            write_d;
	logic                     done_s3;
	logic                     status_s3;
	logic [NL-1:0][GW-1:0]    gain_s3;
	logic [NL-1:0]            write_s3;
	logic                     sat_s3;

	// The pipeline takes a request in every cycle and configuration at any time.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			golden_rg_q <= '0;
			golden_bg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				awbg_pkg::REG_GOLDEN_RG: golden_rg_q <= cfg_data;
				awbg_pkg::REG_GOLDEN_BG: golden_bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 captures the masked ratios and flags any zero among the four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		urg_s1  <= unit_rg[EW-1:0];
		ubg_s1  <= unit_bg[EW-1:0];
		grg_s1  <= golden_rg_q[EW-1:0];
		gbg_s1  <= golden_bg_q[EW-1:0];
		zero_s1 <= (unit_rg[EW-1:0] == '0) || (unit_bg[EW-1:0] == '0) ||
			(golden_rg_q[EW-1:0] == '0) || (golden_bg_q[EW-1:0] == '0);
	end

	// Relative gains: golden times 1000 over measured, one quotient bit per cell. A zero
	// divisor produces a meaningless quotient, which the status flag masks at the end.
	assign rel_num[0] = REL_W'(grg_s1) * REL_W'(awbg_pkg::REL_SCALE);
	assign rel_num[1] = REL_W'(gbg_s1) * REL_W'(awbg_pkg::REL_SCALE);
	assign rel_div[0] = urg_s1;
	assign rel_div[1] = ubg_s1;

	awbg_div_chain #(
		.LANES(2),
		.DW   (EW),
		.NW   (REL_W),
		.SW   (1)
	) u_rel_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_side  (zero_s1),
		.in_rem   ('0),
		.in_div   (rel_div),
		.in_num   (rel_num),
		.out_valid(rel_valid),
		.out_side (rel_side),
		.out_quo  (rel_quo)
	);

	// The base is the smaller relative gain when either falls below 1000, otherwise 1000.
	// It then never exceeds 1000, and a base of zero is taken as one.
	always_comb begin
		lt_r    = rel_quo[0] < REL_W'(awbg_pkg::REL_SCALE);
		lt_b    = rel_quo[1] < REL_W'(awbg_pkg::REL_SCALE);
		min_rel = (rel_quo[0] < rel_quo[1]) ? rel_quo[0] : rel_quo[1];
		base_d  = (lt_r || lt_b) ? min_rel[BW-1:0] : BW'(awbg_pkg::REL_SCALE);
		if (base_d == '0) begin
			base_d = BW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= rel_valid;
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= rel_side[0];
		rel_r_s2  <= rel_quo[0];
		rel_b_s2  <= rel_quo[1];
		base_s2   <= base_d;
	end

	// Each gain is relative gain times 1024 over the base. The top bits of that numerator
	// form the starting remainder; when they already reach the base the quotient cannot
	// fit sixteen bits and the gain saturates, so the chain only has to find the low
	// sixteen quotient bits.
	always_comb begin
		chan_rel[awbg_pkg::LANE_RED]   = rel_r_s2;
		chan_rel[awbg_pkg::LANE_GREEN] = REL_W'(awbg_pkg::REL_SCALE);
		chan_rel[awbg_pkg::LANE_BLUE]  = rel_b_s2;
		for (int l = 0; l < NL; l++) begin
			chan_hi[l]  = chan_rel[l][REL_W-1:awbg_pkg::REL_SHIFT];
			chan_sat[l] = chan_hi[l] >= HI_W'(base_s2);
			gain_rem[l] = chan_sat[l] ? '0 : chan_hi[l][BW-1:0];
			gain_div[l] = base_s2;
			gain_num[l] = {chan_rel[l][awbg_pkg::REL_SHIFT-1:0],
				{awbg_pkg::UNITY_SHIFT{1'b0}}};
		end
	end

	awbg_div_chain #(
		.LANES(NL),
		.DW   (BW),
		.NW   (GW),
		.SW   (NL + 1)
	) u_gain_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_side  ({status_s2, chan_sat}),
		.in_rem   (gain_rem),
		.in_div   (gain_div),
		.in_num   (gain_num),
		.out_valid(gain_valid),
		.out_side (gain_side),
		.out_quo  (gain_quo)
	);

	// Saturated lanes clip to all ones; a zero ratio clears every gain and flag.
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			gain_d[l]  = gain_side[l] ? '1 : gain_quo[l];
			write_d[l] = gain_d[l] > GW'(awbg_pkg::UNITY_GAIN);
			if (gain_side[NL]) begin
				gain_d[l]  = '0;
				write_d[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= gain_valid;
		end
	end

	always_ff @(posedge clk) begin
		status_s3 <= gain_side[NL];
		gain_s3   <= gain_d;
		write_s3  <= write_d;
		sat_s3    <= !gain_side[NL] && (gain_side[NL-1:0] != '0);
	end

	assign done           = done_s3;
	assign status         = status_s3;
	assign red_gain       = gain_s3[awbg_pkg::LANE_RED];
	assign green_gain     = gain_s3[awbg_pkg::LANE_GREEN];
	assign blue_gain      = gain_s3[awbg_pkg::LANE_BLUE];
	assign red_write      = write_s3[awbg_pkg::LANE_RED];
	assign green_write    = write_s3[awbg_pkg::LANE_GREEN];
	assign blue_write     = write_s3[awbg_pkg::LANE_BLUE];
	assign gain_saturated = sat_s3;

endmodule

`default_nettype wire

FILE: design/awbg_checker.sv
// Port level checks on the gain results, bound to the top level.
`default_nettype none

module awbg_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   done,
	input logic                                   status,
	input logic [awbg_pkg::GAIN_W-1:0]            red_gain,
	input logic [awbg_pkg::GAIN_W-1:0]            green_gain,
	input logic [awbg_pkg::GAIN_W-1:0]            blue_gain,
	input logic                                   red_write,
	input logic                                   green_write,
	input logic                                   blue_write,
	input logic                                   gain_saturated
);

	localparam logic [awbg_pkg::GAIN_W-1:0] UNITY = awbg_pkg::GAIN_W'(awbg_pkg::UNITY_GAIN);

	// A zero ratio yields an all zero result.
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> red_gain == '0 && green_gain == '0 && blue_gain == '0 &&
			!red_write && !green_write && !blue_write && !gain_saturated)
		else $error("status result carries non-zero gains or flags");

	// Write flags follow the gains they belong to.
	a_write_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> red_write == (red_gain > UNITY) && green_write == (green_gain > UNITY) &&
			blue_write == (blue_gain > UNITY))
		else $error("write flag disagrees with its gain");

	// Saturation shows up as at least one clipped gain.
	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		done && gain_saturated |-> red_gain == '1 || green_gain == '1 || blue_gain == '1)
		else $error("saturation flagged without a clipped gain");

	// The base never exceeds 1000, so green never falls below unity.
	a_green_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done && !status |-> green_gain >= UNITY)
		else $error("green gain below unity");

endmodule

bind awb_gain_from_ratios awbg_checker u_awbg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.done          (done),
	.status        (status),
	.red_gain      (red_gain),
	.green_gain    (green_gain),
	.blue_gain     (blue_gain),
	.red_write     (red_write),
	.green_write   (green_write),
	.blue_write    (blue_write),
	.gain_saturated(gain_saturated)
);

`default_nettype wire
